// ----- hw/rtl/sitda_pkg.sv -----
package sitda_pkg;

  // Width of the signed input word.
  localparam int unsigned VALUE_BITS = 32;

  // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
  // 30103 / 100000 approximates log10(2) closely enough over 8..64 bits.
  localparam int unsigned BCD_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_BITS   = 4 * BCD_DIGITS;

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned DIG_W = $clog2(BCD_DIGITS + 1);

  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

endpackage

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII. Each input beat carries one signed
// two's-complement word; the block answers with its decimal text, one ASCII
// character per output beat, most significant first: a leading '-' for
// negative values, no leading zeros, a lone '0' for zero, and tlast on the
// final character. The most negative value prints exactly (its magnitude is
// formed unsigned). One number is converted at a time: the magnitude is
// shifted bit by bit through a double-dabble BCD register (one input bit per
// cycle), leading zero digits are then dropped one per cycle, and the
// remaining characters leave one per cycle while the output does not stall.
// The last character sits in an output register, so the next number is
// taken and converted while that beat still waits.
module signed_int_to_decimal_ascii (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value (signed)
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,    // [6:0] character, [7] zero fill
  output logic       m_axis_tlast_o     // is_last
);

  localparam int unsigned VB = sitda_pkg::VALUE_BITS;
  localparam int unsigned BB = sitda_pkg::BCD_BITS;
  localparam int unsigned ND = sitda_pkg::BCD_DIGITS;
  localparam int unsigned CW = sitda_pkg::CNT_W;
  localparam int unsigned DW = sitda_pkg::DIG_W;
  localparam int unsigned XW = sitda_pkg::CHAR_W;

  sitda_pkg::state_e state_q, state_d;

  logic [VB-1:0] bin_q, bin_d;     // magnitude, shifted out MSB first
  logic [BB-1:0] bcd_q, bcd_d;     // packed BCD, most significant digit on top
  logic          neg_q, neg_d;     // minus sign still to send
  logic [CW-1:0] cnt_q, cnt_d;     // binary bits left to shift in
  logic [DW-1:0] dig_q, dig_d;     // BCD digits left in the register

  logic          m_valid_q, m_valid_d;
  logic [XW-1:0] m_char_q, m_char_d;
  logic          m_last_q, m_last_d;

  logic [VB-1:0] in_val;
  logic [VB-1:0] in_mag;
  logic          in_neg;
  logic [BB-1:0] bcd_adj;
  logic [3:0]    top_dig;
  logic          out_free;
  logic          in_fire;

  assign in_val  = s_axis_tdata_i[VB-1:0];
  assign in_neg  = in_val[VB-1];
  assign in_mag  = in_neg ? (~in_val + VB'(1)) : in_val;
  assign top_dig = bcd_q[BB-1 -: 4];

  assign s_axis_tready_o = (state_q == sitda_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  // Double-dabble correction: any digit of 5 or more gets +3 before the shift.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    dig_d     = dig_q;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;

    unique case (state_q)
      sitda_pkg::ST_IDLE: begin
        if (in_fire) begin
          bin_d   = in_mag;
          bcd_d   = '0;
          neg_d   = in_neg;
          cnt_d   = CW'(VB);
          state_d = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        bcd_d = {bcd_adj[BB-2:0], bin_q[VB-1]};
        bin_d = {bin_q[VB-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          dig_d   = DW'(ND);
          state_d = sitda_pkg::ST_SKIP;
        end
      end
      sitda_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_dig == 4'd0 && dig_q != DW'(1)) begin
          bcd_d = {bcd_q[BB-5:0], 4'd0};
          dig_d = dig_q - DW'(1);
        end else begin
          state_d = sitda_pkg::ST_EMIT;
        end
      end
      sitda_pkg::ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (neg_q) begin
            m_char_d = sitda_pkg::CHAR_MINUS;
            m_last_d = 1'b0;
            neg_d    = 1'b0;
          end else begin
            m_char_d = sitda_pkg::CHAR_ZERO + {3'd0, top_dig};
            m_last_d = (dig_q == DW'(1));
            bcd_d    = {bcd_q[BB-5:0], 4'd0};
            dig_d    = dig_q - DW'(1);
            if (dig_q == DW'(1)) begin
              state_d = sitda_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_d = sitda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sitda_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      neg_q     <= 1'b0;
      cnt_q     <= '0;
      dig_q     <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      neg_q     <= neg_d;
      cnt_q     <= cnt_d;
      dig_q     <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    m_char_q <= m_char_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_char_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ----- tb/sitda_text_checker.sv -----
module sitda_text_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [31:0]       s_tdata_i,     // [31:0] value (signed)
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [7:0]        m_tdata_i,     // [6:0] character, [7] zero fill
  input  logic              m_tlast_i,     // is_last
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sitda_pkg::CHAR_W-1:0] code;
    logic                         last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t char_q[$];
  int unsigned errs = 0;

  // Decimal text of one value: optional minus, then digits, MSD first.
  function automatic void queue_decimal_text(input logic [31:0] value);
    logic [63:0] mask;
    logic [63:0] word;
    logic [63:0] mag;
    logic [3:0]  digit_buf[20];
    int          nd;
    text_char_t  c;
    mask = (64'd2 << (sitda_pkg::VALUE_BITS - 1)) - 64'd1;
    word = {32'd0, value} & mask;
    if (word[sitda_pkg::VALUE_BITS-1]) begin
      // magnitude formed unsigned, so the most negative value is exact
      mag    = (~word + 64'd1) & mask;
      c.code = sitda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      char_q.push_back(c);
    end else begin
      mag = word;
    end
    nd = 0;
    do begin
      digit_buf[nd] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      nd++;
    end while (mag != 0 && nd < 20);
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digit_buf[i]);
      c.last = (i == 0);
      char_q.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    text_char_t want;
    if (rst_ni) begin
      // output side first: a beat leaving now never belongs to a number taken now
      if (m_tvalid_i && m_tready_i) begin
        if (char_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: output beat with nothing pending: char %0d last %b",
                     $realtime, m_tdata_i[sitda_pkg::CHAR_W-1:0], m_tlast_i);
        end else begin
          want = char_q.pop_front();
          if (m_tdata_i[sitda_pkg::CHAR_W-1:0] !== want.code ||
              m_tlast_i !== want.last) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch: char exp %0d got %0d, last exp %b got %b",
                       $realtime, want.code, m_tdata_i[sitda_pkg::CHAR_W-1:0],
                       want.last, m_tlast_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        queue_decimal_text(s_tdata_i);
    end
    fail_count_o <= errs;
    pending_o    <= char_q.size();
  end

endmodule

// ----- tb/signed_int_to_decimal_ascii_test.sv -----
module signed_int_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest run: ~460 numbers, each a conversion plus up to 11 stalled chars
  // and an input gap, plus the long hold-off; the limit leaves several times that.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;   // long sink hold-off
  localparam int unsigned TAIL_CYCLES = 60;    // longer than one conversion

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        s_tvalid   = 1'b0;
  logic [31:0] s_tdata    = '0;
  logic        m_tready   = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int unsigned fail_count;
  int unsigned pending;      // characters the checker still waits for
  int unsigned cycles = 0;

  bit idle_on  = 1'b1;       // random idle bursts on both sides
  bit hold_req = 1'b0;       // ask the sink for one long hold-off

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  signed_int_to_decimal_ascii dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  sitda_text_checker text_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sink: ready runs of random length broken by short idle bursts, plus one
  // long hold-off on request so the block backs up and drops s_tready.
  initial begin : sink
    int unsigned busy_left;
    bit          hold_done;
    busy_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && busy_left == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        busy_left = $urandom_range(1, 40);
      end else begin
        m_tready <= 1'b1;
        if (busy_left > 0) busy_left--;
      end
    end
  end

  // One input beat; tvalid stays high into the next beat unless an idle
  // burst follows, so it is never lowered and raised in the same step.
  task automatic push_value(input logic [31:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Source goes quiet until every owed character has left, then lets the
  // block finish its last conversion.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Random value spread over all text lengths: full-range words, small
  // numbers, a random decade, values near the extremes, powers of ten +-1.
  function automatic logic [31:0] pick_value();
    longint p;
    longint lo;
    longint hi;
    longint v;
    int     k;
    k = $urandom_range(0, 9);
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    case ($urandom_range(0, 4))
      0: v = longint'($urandom);
      1: v = $urandom_range(0, 99);
      2: begin
        lo = p;
        hi = p * 10 - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        v = lo + (longint'($urandom) % (hi - lo + 1));
      end
      3: begin
        if ($urandom_range(0, 1)) v = 64'sd2147483647 - $urandom_range(0, 20);
        else v = 64'sd2147483648 - $urandom_range(0, 20);
      end
      default: v = p + $urandom_range(0, 2) - 1;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v[31:0];
  endfunction

  initial begin : stimulus
    // zero, single digits, some decade edges, both extremes and neighbors
    logic [31:0] directed[$] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      -32'sd9, 32'd7, 32'd123456789, -32'sd987654321, 32'd999999999,
      32'd1000000000, -32'sd1000000000, 32'd1999999999,
      32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000, 32'h8000_0001,
      32'hffff_fffe, 32'd1234567890
    };
    int unsigned n;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) push_value(directed[i]);
    settle();

    // main random phase with idling; one long sink hold-off in the middle
    for (n = 0; n < 300; n++) begin
      if (n == 120) hold_req = 1'b1;
      push_value(pick_value());
    end

    // closing phase at full rate on both sides
    idle_on = 1'b0;
    for (n = 0; n < 140; n++) push_value(pick_value());
    settle();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sitda_pkg.sv
hw/rtl/signed_int_to_decimal_ascii.sv
tb/sitda_text_checker.sv
tb/signed_int_to_decimal_ascii_test.sv
